### hdl/pwm6_pkg.sv
// Package with the constants, types and pin decode shared by the six-channel PWM.
`default_nettype none

package pwm6_pkg;

  localparam int unsigned NumChannels = 6;
  localparam int unsigned NumHead     = 2;
  localparam int unsigned NumTail     = 4;

  localparam logic [15:0] PeriodReset = 16'd1000;
  localparam logic [7:0]  DutyFull    = 8'd255;

  localparam logic        OpTick  = 1'b0;
  localparam logic        OpWrite = 1'b1;

  localparam logic [1:0]  PortPwm = 2'd0;

  localparam logic [4:0]  PinHead0 = 5'd7;
  localparam logic [4:0]  PinHead1 = 5'd21;
  localparam logic [4:0]  PinTail0 = 5'd12;
  localparam logic [4:0]  PinTail1 = 5'd13;
  localparam logic [4:0]  PinTail2 = 5'd17;
  localparam logic [4:0]  PinTail3 = 5'd22;

  // Channel numbers follow the bit order of the level output.
  typedef logic [2:0] chan_t;

  localparam chan_t ChHead0 = 3'd0;
  localparam chan_t ChHead1 = 3'd1;
  localparam chan_t ChTail0 = 3'd2;
  localparam chan_t ChTail1 = 3'd3;
  localparam chan_t ChTail2 = 3'd4;
  localparam chan_t ChTail3 = 3'd5;

  typedef struct packed {
    logic  hit;
    chan_t ch;
  } chan_sel_t;

  function automatic chan_sel_t decode_pin(input logic [4:0] pin);
    chan_sel_t sel;
    sel.hit = 1'b1;
    sel.ch  = ChHead0;
    unique case (pin)
      PinHead0: sel.ch = ChHead0;
      PinHead1: sel.ch = ChHead1;
      PinTail0: sel.ch = ChTail0;
      PinTail1: sel.ch = ChTail1;
      PinTail2: sel.ch = ChTail2;
      PinTail3: sel.ch = ChTail3;
      default:  sel.hit = 1'b0;
    endcase
    return sel;
  endfunction

  // Requested duty limited to 0..255.
  function automatic logic [7:0] clamp_duty(input logic signed [9:0] value);
    logic [7:0] duty;
    if (value[9]) begin
      duty = 8'd0;
    end else if (value[8]) begin
      duty = DutyFull;
    end else begin
      duty = value[7:0];
    end
    return duty;
  endfunction

endpackage

`default_nettype wire

### hdl/six_channel_dual_mode_pwm.sv
// Six-channel PWM with two head-aligned and four tail-aligned outputs.
`default_nettype none

// Each input item is either one tick of the shared period counter or a duty
// write to a port-0 pin, and every item yields exactly one result item with
// the six channel levels after that item. The block accepts one item per
// cycle while in_stall_o is low. An accepted item passes through the
// input register, a 16x8 multiply of period and duty, a reciprocal stage
// that divides by 255, and the stage that updates the counter and on times.
// The levels are formed from the updated state as the result register loads.
// The period register may be written only while no item is in flight.
module six_channel_dual_mode_pwm (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic        [15:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               operation_i,
  input  wire logic        [1:0]  port_i,
  input  wire logic        [4:0]  pin_i,
  input  wire logic signed [9:0]  value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic             [5:0]  pin_levels_o,
  output logic                    period_start_o,
  output logic                    write_hit_o
);
  import pwm6_pkg::*;

  logic [15:0] period_q;
  logic [15:0] eff_period;

  // Stage 1: accepted item.
  logic              s1_valid_q;
  logic              s1_op_q;
  logic [1:0]        s1_port_q;
  logic [4:0]        s1_pin_q;
  logic signed [9:0] s1_value_q;

  // Stage 2: decoded channel and period times duty.
  logic        s2_valid_q;
  logic        s2_op_q;
  chan_sel_t   s2_sel_q;
  logic [23:0] s2_prod_q;

  // Stage 3: on time in ticks.
  logic        s3_valid_q;
  logic        s3_op_q;
  chan_sel_t   s3_sel_q;
  logic [15:0] s3_on_q;

  // Stage 4: flags of an item whose state update is done.
  logic s4_valid_q;
  logic s4_wrap_q;
  logic s4_hit_q;

  logic       out_valid_q;
  logic [5:0] out_levels_q;
  logic       out_wrap_q;
  logic       out_hit_q;

  logic rdy_out, rdy4, rdy3, rdy2, rdy1;

  logic [15:0] count_q;
  logic [15:0] head_active_q [NumHead];
  logic [15:0] head_pending_q [NumHead];
  logic [15:0] tail_on_q [NumTail];
  logic [5:0]  chan_en_q;

  chan_sel_t   s1_sel;
  logic [7:0]  s1_duty;
  logic [24:0] prod_inc;
  logic [40:0] recip_sum;
  logic        s3_fire;
  logic [16:0] count_inc;
  logic        wrap_now;
  logic        hit_now;
  logic [1:0]  tail_idx;
  logic [5:0]  levels;

  assign eff_period = (period_q == 16'd0) ? 16'd1 : period_q;

  // Each stage moves on when it is empty or the stage after it moves on.
  assign rdy_out    = !out_valid_q || !out_stall_i;
  assign rdy4       = !s4_valid_q || rdy_out;
  assign rdy3       = !s3_valid_q || rdy4;
  assign rdy2       = !s2_valid_q || rdy3;
  assign rdy1       = !s1_valid_q || rdy2;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  // Stage 1.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rdy1) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_op_q    <= operation_i;
      s1_port_q  <= port_i;
      s1_pin_q   <= pin_i;
      s1_value_q <= value_i;
    end
  end

  // Stage 2.
  always_comb begin
    s1_sel     = decode_pin(s1_pin_q);
    s1_sel.hit = s1_sel.hit && (s1_port_q == PortPwm) && (s1_op_q == OpWrite);
    s1_duty    = clamp_duty(s1_value_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (rdy2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && s1_valid_q) begin
      s2_op_q   <= s1_op_q;
      s2_sel_q  <= s1_sel;
      s2_prod_q <= {8'd0, eff_period} * {16'd0, s1_duty};
    end
  end

  // Stage 3: x / 255 equals ((x + 1) * 0x10101) >> 24 for every x below 2^24.
  assign prod_inc  = {1'b0, s2_prod_q} + 25'd1;
  assign recip_sum = {prod_inc, 16'd0} + {8'd0, prod_inc, 8'd0} + {16'd0, prod_inc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (rdy3) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && s2_valid_q) begin
      s3_op_q  <= s2_op_q;
      s3_sel_q <= s2_sel_q;
      s3_on_q  <= recip_sum[39:24];
    end
  end

  // State update as the item leaves stage 3.
  assign s3_fire   = s3_valid_q && rdy4;
  assign count_inc = {1'b0, count_q} + 17'd1;
  assign wrap_now  = (s3_op_q == OpTick) && (count_inc >= {1'b0, eff_period});
  assign hit_now   = s3_sel_q.hit;
  assign tail_idx  = 2'(s3_sel_q.ch - ChTail0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= 16'd0;
      chan_en_q <= '0;
      for (int i = 0; i < NumHead; i++) begin
        head_active_q[i]  <= 16'd0;
        head_pending_q[i] <= 16'd0;
      end
      for (int i = 0; i < NumTail; i++) begin
        tail_on_q[i] <= 16'd0;
      end
    end else if (s3_fire) begin
      if (s3_op_q == OpTick) begin
        if (wrap_now) begin
          count_q <= 16'd0;
          for (int i = 0; i < NumHead; i++) begin
            head_active_q[i] <= head_pending_q[i];
          end
        end else begin
          count_q <= count_inc[15:0];
        end
      end else if (hit_now) begin
        chan_en_q[s3_sel_q.ch] <= 1'b1;
        if (s3_sel_q.ch == ChHead0 || s3_sel_q.ch == ChHead1) begin
          head_pending_q[s3_sel_q.ch[0]] <= s3_on_q;
        end else begin
          tail_on_q[tail_idx] <= s3_on_q;
        end
      end
    end
  end

  // Stage 4.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (rdy4) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_fire) begin
      s4_wrap_q <= wrap_now;
      s4_hit_q  <= hit_now;
    end
  end

  // Levels from the state that the item in stage 4 left behind.
  always_comb begin
    for (int i = 0; i < NumHead; i++) begin
      levels[i] = chan_en_q[i] && (count_q < head_active_q[i]);
    end
    for (int i = 0; i < NumTail; i++) begin
      levels[NumHead + i] = chan_en_q[NumHead + i] && (tail_on_q[i] != 16'd0) &&
                            ((tail_on_q[i] >= eff_period) ||
                             (count_q >= eff_period - tail_on_q[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy_out) begin
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out && s4_valid_q) begin
      out_levels_q <= levels;
      out_wrap_q   <= s4_wrap_q;
      out_hit_q    <= s4_hit_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pin_levels_o   = out_levels_q;
  assign period_start_o = out_wrap_q;
  assign write_hit_o    = out_hit_q;

  // A result is a tick or a write, so it never reports both a wrap and a hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(period_start_o && write_hit_o))
    else $error("result reports both period start and write hit");

  // Channels only get enabled, so a high level always has its enable set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((pin_levels_o & ~chan_en_q) == 6'd0))
    else $error("disabled channel shows a high level");

  // The counter only steps by one or wraps to zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == 16'd0 || count_q == $past(count_q) + 16'd1))
    else $error("period counter jumped");

  // An empty input stage never holds off a new item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with an empty input stage");

endmodule

`default_nettype wire

### tb/six_channel_dual_mode_pwm_tb.sv
// Testbench for the six-channel PWM: ticks and duty writes checked against a predictor.
`timescale 1ns / 1ps

import pwm6_pkg::*;

// Predicts the channel levels and flags of every item and checks the results in order.
class pwm_level_predictor;
  localparam int unsigned MaxReports = 10;

  logic [15:0] period_reg;
  logic [15:0] count;
  logic [15:0] head_active [NumHead];
  logic [15:0] head_pending [NumHead];
  logic [15:0] tail_on [NumTail];
  logic [5:0]  enabled;
  logic [5:0]  levels_q [$];
  logic        start_q [$];
  logic        hit_q [$];
  int unsigned fail_count;

  function new();
    period_reg = PeriodReset;
    count      = '0;
    enabled    = '0;
    fail_count = 0;
    for (int i = 0; i < NumHead; i++) begin
      head_active[i]  = '0;
      head_pending[i] = '0;
    end
    for (int i = 0; i < NumTail; i++) begin
      tail_on[i] = '0;
    end
  endfunction

  function void set_period(logic [15:0] ticks);
    period_reg = ticks;
  endfunction

  function int unsigned pending();
    return levels_q.size();
  endfunction

  function void note_item(logic op, logic [1:0] port, logic [4:0] pin,
                          logic signed [9:0] value);
    int unsigned span;
    int unsigned next;
    int unsigned duty;
    int unsigned on_ticks;
    int          chan;
    logic [5:0]  lv;
    logic        start;
    logic        hit;
    // A zero period behaves like a period of one tick.
    span  = (period_reg == 0) ? 1 : period_reg;
    start = 1'b0;
    hit   = 1'b0;
    if (op == OpTick) begin
      next = count + 1;
      if (next >= span) begin
        next        = 0;
        start       = 1'b1;
        head_active = head_pending;
      end
      count = next[15:0];
    end else if (port == PortPwm) begin
      if (int'(value) < 0) begin
        duty = 0;
      end else if (int'(value) > int'(DutyFull)) begin
        duty = int'(DutyFull);
      end else begin
        duty = int'(value);
      end
      on_ticks = span * duty / int'(DutyFull);
      chan = -1;
      case (pin)
        PinHead0: chan = int'(ChHead0);
        PinHead1: chan = int'(ChHead1);
        PinTail0: chan = int'(ChTail0);
        PinTail1: chan = int'(ChTail1);
        PinTail2: chan = int'(ChTail2);
        PinTail3: chan = int'(ChTail3);
        default:  chan = -1;
      endcase
      if (chan >= 0) begin
        hit           = 1'b1;
        enabled[chan] = 1'b1;
        if (chan < int'(NumHead)) begin
          head_pending[chan] = on_ticks[15:0];
        end else begin
          tail_on[chan - NumHead] = on_ticks[15:0];
        end
      end
    end
    lv = '0;
    for (int i = 0; i < NumHead; i++) begin
      lv[i] = enabled[i] && (count < head_active[i]);
    end
    // A stored on time may exceed a lowered period; the channel is then always high.
    for (int i = 0; i < NumTail; i++) begin
      lv[NumHead + i] = enabled[NumHead + i] && (tail_on[i] != 0) &&
                        ((tail_on[i] >= span) || (count >= span - tail_on[i]));
    end
    levels_q.push_back(lv);
    start_q.push_back(start);
    hit_q.push_back(hit);
  endfunction

  function void check_result(logic [5:0] lv, logic start, logic hit);
    logic [5:0] want_lv;
    logic       want_start;
    logic       want_hit;
    if (levels_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MaxReports) begin
        $display("%0t: result with no item waiting: levels %b period_start %b write_hit %b",
                 $time, lv, start, hit);
      end
      return;
    end
    want_lv    = levels_q.pop_front();
    want_start = start_q.pop_front();
    want_hit   = hit_q.pop_front();
    if (lv !== want_lv || start !== want_start || hit !== want_hit) begin
      fail_count++;
      if (fail_count <= MaxReports) begin
        $display("%0t: mismatch: levels exp %b got %b, period_start exp %b got %b, %s %b got %b",
                 $time, want_lv, lv, want_start, start, "write_hit exp", want_hit, hit);
      end
    end
  endfunction
endclass

module six_channel_dual_mode_pwm_tb;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseItems   = 95;

  typedef enum int unsigned {StallNone, StallLight, StallHeavy, StallEvery4} stall_mode_e;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [15:0]       cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              operation_i;
  logic [1:0]        port_i;
  logic [4:0]        pin_i;
  logic signed [9:0] value_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [5:0]        pin_levels_o;
  logic              period_start_o;
  logic              write_hit_o;

  pwm_level_predictor duty_model;
  int unsigned        cycle_count;

  six_channel_dual_mode_pwm i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .port_i         (port_i),
    .pin_i          (pin_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pin_levels_o   (pin_levels_o),
    .period_start_o (period_start_o),
    .write_hit_o    (write_hit_o)
  );

  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL six_channel_dual_mode_pwm");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      duty_model.check_result(pin_levels_o, period_start_o, write_hit_o);
    end
  end

  // The receiver switches between randomly chosen stall patterns.
  initial begin
    stall_mode_e mode;
    out_stall_i = 1'b0;
    forever begin
      mode = stall_mode_e'($urandom_range(3));
      for (int step = 0; step < 48; step++) begin
        @(negedge clk_i);
        case (mode)
          StallNone:   out_stall_i = 1'b0;
          StallLight:  out_stall_i = ($urandom_range(99) < 30);
          StallHeavy:  out_stall_i = ($urandom_range(99) < 75);
          StallEvery4: out_stall_i = (step % 4 != 0);
          default:     out_stall_i = 1'b0;
        endcase
      end
    end
  end

  task automatic send_item(logic op, logic [1:0] port, logic [4:0] pin,
                           logic signed [9:0] value);
    @(negedge clk_i);
    in_valid_i  = 1'b1;
    operation_i = op;
    port_i      = port;
    pin_i       = pin;
    value_i     = value;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    duty_model.note_item(op, port, pin, value);
  endtask

  task automatic pause_sender(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
  endtask

  task automatic wait_idle();
    pause_sender(1);
    while (duty_model.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_period(logic [15:0] ticks);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = ticks;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    duty_model.set_period(ticks);
  endtask

  task automatic run_random(int unsigned items);
    logic [4:0]        mapped_pins [6];
    logic signed [9:0] edge_values [6];
    int unsigned       burst_left;
    logic              op;
    logic [1:0]        port;
    logic [4:0]        pin;
    logic signed [9:0] value;
    int unsigned       roll;
    mapped_pins = '{PinHead0, PinHead1, PinTail0, PinTail1, PinTail2, PinTail3};
    edge_values = '{-10'sd512, -10'sd1, 10'sd0, 10'sd255, 10'sd256, 10'sd511};
    burst_left  = 0;
    for (int n = 0; n < items; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        // Many bursts follow the previous one with no gap at all.
        if ($urandom_range(99) < 60) begin
          pause_sender($urandom_range(1, 7));
        end
      end
      burst_left--;
      op   = ($urandom_range(99) < 50) ? OpTick : OpWrite;
      port = ($urandom_range(99) < 85) ? PortPwm : 2'($urandom_range(3));
      pin  = ($urandom_range(99) < 80) ? mapped_pins[$urandom_range(5)]
                                       : 5'($urandom_range(31));
      roll = $urandom_range(99);
      if (roll < 25) begin
        value = 10'($urandom);
      end else if (roll < 40) begin
        value = edge_values[$urandom_range(5)];
      end else begin
        value = 10'($urandom_range(255));
      end
      send_item(op, port, pin, value);
    end
  endtask

  initial begin
    int unsigned phase_periods [10];
    duty_model   = new();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    operation_i  = OpTick;
    port_i       = '0;
    pin_i        = '0;
    value_i      = '0;
    phase_periods = '{2, 0, 7, 1, 16, 65535, 5, 40, 3, 1000};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed items at the reset period: clamping, every channel, ignored writes.
    send_item(OpTick, PortPwm, PinHead0, 10'sd0);
    send_item(OpWrite, PortPwm, PinHead0, 10'sd511);
    send_item(OpWrite, PortPwm, PinHead1, 10'sd128);
    send_item(OpWrite, PortPwm, PinTail0, -10'sd512);
    send_item(OpWrite, PortPwm, PinTail1, 10'sd255);
    send_item(OpWrite, PortPwm, PinTail2, 10'sd256);
    send_item(OpWrite, PortPwm, PinTail3, -10'sd1);
    send_item(OpWrite, 2'd1, PinHead0, 10'sd100);
    send_item(OpWrite, 2'd2, PinTail0, 10'sd1);
    send_item(OpWrite, 2'd3, 5'd31, 10'sd511);
    send_item(OpWrite, PortPwm, 5'd0, 10'sd200);
    send_item(OpWrite, PortPwm, 5'd31, 10'sd200);
    repeat (5) send_item(OpTick, 2'd3, 5'd31, -10'sd1);
    // The counter now sits past the new, shorter period and some stored on times exceed it.
    set_period(16'd3);
    repeat (4) send_item(OpTick, PortPwm, PinHead1, 10'sd0);
    send_item(OpWrite, PortPwm, PinTail1, 10'sd1);
    send_item(OpWrite, PortPwm, PinTail0, 10'sd85);
    repeat (3) send_item(OpTick, PortPwm, PinTail0, 10'sd0);

    foreach (phase_periods[i]) begin
      set_period(phase_periods[i][15:0]);
      run_random(PhaseItems);
    end
    set_period(16'($urandom_range(1, 65535)));
    run_random(PhaseItems);

    wait_idle();
    if (duty_model.fail_count == 0 && duty_model.pending() == 0) begin
      $display("PASS six_channel_dual_mode_pwm");
    end else begin
      $display("FAIL six_channel_dual_mode_pwm");
    end
    $finish;
  end
endmodule

### sim.f
hdl/pwm6_pkg.sv
hdl/six_channel_dual_mode_pwm.sv
tb/six_channel_dual_mode_pwm_tb.sv
